// ===== hdl/wtw_pkg.sv =====
`default_nettype none
package wtw_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_START  = 3'd0;
  localparam logic [2:0] REG_FINISH = 3'd1;
  localparam logic [2:0] REG_PERIOD = 3'd2;
  localparam logic [2:0] REG_PHASE  = 3'd3;
  localparam logic [2:0] REG_AMPL   = 3'd4;
  localparam logic [2:0] REG_ZERO   = 3'd5;

  // Stages of the two per-sample dividers.
  localparam int MOD_STAGES = 34;
  localparam int DIV_STAGES = 32;

  // Iterations of the setup divider.
  localparam int SEQ_STEPS = 64;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_MUL,
    SEQ_LOAD,
    SEQ_DIV,
    SEQ_FIX,
    SEQ_MOD,
    SEQ_DONE
  } seq_state_t;

  // One restoring step against a 31-bit divisor: {quotient bit, new remainder}.
  // The remainder coming in is always below the divisor.
  function automatic logic [31:0] rem_step(logic [30:0] rem, logic bit_in,
                                           logic [30:0] dvs);
    logic [31:0] t;
    t = {rem, bit_in};
    if (t >= {1'b0, dvs}) begin
      rem_step = {1'b1, 31'(t - {1'b0, dvs})};
    end else begin
      rem_step = {1'b0, t[30:0]};
    end
  endfunction

endpackage
`default_nettype wire

// ===== hdl/windowed_triangle_wave.sv =====
`default_nettype none
// Channel   Dir  Handshake          Payload
// s_axis    in   tvalid / tready    tdata[31:0] = sample_time
// m_axis    out  tvalid / tready    tdata[31:0] = factor, tuser = in_window
// cfg       in   cfg_we             cfg_addr = register index, cfg_data = value
//
// One sample enters per cycle while s_axis_tready is high.
// The pipeline is made of the two bit-per-stage dividers (34 stages for the
// period reduction, 32 for the scaling by the period) plus seven other stages.
// After every register write a shared iterative divider works out the phase
// correction; s_axis_tready is low while it runs.
// Reset is synchronous and active high and leaves the registers at their
// reset values with the phase correction already valid.
// With m_axis_tvalid high and m_axis_tready low all stages hold; nothing is lost.
module windowed_triangle_wave #(
  parameter int FRAC_BITS = wtw_pkg::FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] sample_time
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] factor
  output logic             m_axis_tuser,   // [0] in_window
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [31:0] cfg_data
);

  localparam int NM = wtw_pkg::MOD_STAGES;
  localparam int ND = wtw_pkg::DIV_STAGES;
  localparam int CW = $clog2(wtw_pkg::SEQ_STEPS);
  localparam logic [30:0] P_ONE = 31'(1) << FRAC_BITS;
  localparam logic [31:0] A_ONE = 32'(1) << FRAC_BITS;

  // Configuration registers.
  logic signed [31:0] start_time, finish_time, phase_offset, amplitude, zero_offset;
  logic [30:0] wave_period;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time   <= '0;
      finish_time  <= '0;
      wave_period  <= P_ONE;
      phase_offset <= '0;
      amplitude    <= A_ONE;
      zero_offset  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        wtw_pkg::REG_START:  start_time   <= cfg_data;
        wtw_pkg::REG_FINISH: finish_time  <= cfg_data;
        wtw_pkg::REG_PERIOD: wave_period  <= cfg_data[30:0];
        wtw_pkg::REG_PHASE:  phase_offset <= cfg_data;
        wtw_pkg::REG_AMPL:   amplitude    <= cfg_data;
        wtw_pkg::REG_ZERO:   zero_offset  <= cfg_data;
        default: ;
      endcase
    end
  end

  // A zero period behaves as one time unit.
  logic [30:0] peff;
  assign peff = (wave_period == '0) ? P_ONE : wave_period;

  // ------------------------------------------------------------------
  // Setup sequencer. The phase correction d = floor(Z*P / (4A)) depends on
  // the registers alone, so it is computed once after each write and kept
  // reduced modulo the period as dm. The same shift-subtract divider first
  // divides |Z*P| by |4A| and then reduces |d| by P.
  // ------------------------------------------------------------------
  wtw_pkg::seq_state_t state, state_next;
  logic               seq_busy, seq_step;
  logic signed [63:0] seq_zp;
  logic signed [33:0] seq_den;
  logic [63:0]        sq_num;
  logic [33:0]        sq_rem, sq_div;
  logic               sq_neg;
  logic [CW-1:0]      cnt;
  logic [30:0]        dm;
  logic [34:0]        sq_t;
  logic               sq_ge;

  always_comb begin
    state_next = state;
    case (state)
      wtw_pkg::SEQ_IDLE: state_next = state;
      wtw_pkg::SEQ_MUL:  state_next = wtw_pkg::SEQ_LOAD;
      wtw_pkg::SEQ_LOAD: state_next = wtw_pkg::SEQ_DIV;
      wtw_pkg::SEQ_DIV:  if (cnt == '1) state_next = wtw_pkg::SEQ_FIX;
      wtw_pkg::SEQ_FIX:  state_next = wtw_pkg::SEQ_MOD;
      wtw_pkg::SEQ_MOD:  if (cnt == '1) state_next = wtw_pkg::SEQ_DONE;
      wtw_pkg::SEQ_DONE: state_next = wtw_pkg::SEQ_IDLE;
      default:           state_next = wtw_pkg::SEQ_IDLE;
    endcase
    if (cfg_we) state_next = wtw_pkg::SEQ_MUL;
  end

  always_comb begin
    seq_busy = (state != wtw_pkg::SEQ_IDLE);
    seq_step = (state == wtw_pkg::SEQ_DIV) || (state == wtw_pkg::SEQ_MOD);
  end

  assign sq_t  = {sq_rem, sq_num[63]};
  assign sq_ge = (sq_t >= {1'b0, sq_div});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wtw_pkg::SEQ_IDLE;
      dm    <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      case (state)
        wtw_pkg::SEQ_MUL: begin
          seq_zp  <= zero_offset * $signed({1'b0, peff});
          seq_den <= {amplitude, 2'b00};
        end
        wtw_pkg::SEQ_LOAD: begin
          sq_neg <= seq_zp[63] ^ seq_den[33];
          sq_num <= seq_zp[63] ? 64'(-seq_zp) : 64'(seq_zp);
          sq_div <= seq_den[33] ? 34'(-seq_den) : 34'(seq_den);
          sq_rem <= '0;
          cnt    <= '0;
        end
        wtw_pkg::SEQ_FIX: begin
          // |d| rounded toward minus infinity for a negative quotient.
          sq_num <= (sq_neg && sq_rem != '0) ? sq_num + 64'd1 : sq_num;
          sq_div <= {3'b000, peff};
          sq_rem <= '0;
          cnt    <= '0;
        end
        wtw_pkg::SEQ_DONE: begin
          dm <= (sq_neg && sq_rem != '0) ? peff - sq_rem[30:0] : sq_rem[30:0];
        end
        default: ;
      endcase
      if (seq_step) begin
        sq_rem <= sq_ge ? 34'(sq_t - {1'b0, sq_div}) : sq_t[33:0];
        sq_num <= {sq_num[62:0], sq_ge};
        cnt    <= cnt + CW'(1);
      end
    end
  end

  // ------------------------------------------------------------------
  // Sample pipeline. All stages move together when the output register
  // is free or being emptied.
  // ------------------------------------------------------------------
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !seq_busy && !cfg_we;

  // Entry: window test and the shifted time u = t + phase - start - dm.
  logic signed [31:0] t_in;
  logic signed [35:0] v;
  assign t_in = s_axis_tdata;
  assign v = 36'(t_in) + 36'(phase_offset) - 36'(start_time) - $signed({5'b0, dm});

  logic        a_vld, a_win, a_neg;
  logic [33:0] a_mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else if (en) begin
      a_vld <= s_axis_tvalid && s_axis_tready;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      a_win <= (t_in >= start_time) && (t_in <= finish_time);
      a_neg <= v[35];
      a_mag <= v[35] ? 34'(-v) : 34'(v);
    end
  end

  // Period reduction: one magnitude bit per stage, most significant first.
  logic        m_vld [NM];
  logic        m_win [NM];
  logic        m_neg [NM];
  logic [30:0] m_rem [NM];
  logic [33:0] m_mag [NM];
  logic [31:0] m_res [NM];

  always_comb begin
    for (int k = 0; k < NM; k++) begin
      if (k == 0) begin
        m_res[k] = wtw_pkg::rem_step('0, a_mag[33], peff);
      end else begin
        m_res[k] = wtw_pkg::rem_step(m_rem[k-1], m_mag[k-1][33], peff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NM; k++) m_vld[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < NM; k++) m_vld[k] <= (k == 0) ? a_vld : m_vld[k-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NM; k++) begin
        m_rem[k] <= m_res[k][30:0];
        if (k == 0) begin
          m_win[k] <= a_win;
          m_neg[k] <= a_neg;
          m_mag[k] <= {a_mag[32:0], 1'b0};
        end else begin
          m_win[k] <= m_win[k-1];
          m_neg[k] <= m_neg[k-1];
          m_mag[k] <= {m_mag[k-1][32:0], 1'b0};
        end
      end
    end
  end

  // Remainder taken into 0..P-1, then the triangle shape.
  logic        f_vld, f_win, g_vld, g_win, h_vld, h_win, i_vld, i_win;
  logic [30:0] f_r;
  logic signed [32:0] g_m;
  logic signed [64:0] h_prod;
  logic        i_neg;
  logic [62:0] i_mag;

  logic [32:0] r4, p1, p3;
  logic signed [34:0] m_t;
  assign r4 = {f_r, 2'b00};
  assign p1 = {2'b00, peff};
  assign p3 = p1 + {1'b0, peff, 1'b0};

  always_comb begin
    if (r4 < p1) begin
      m_t = $signed({2'b00, r4});
    end else if (r4 < p3) begin
      m_t = $signed({3'b000, peff, 1'b0}) - $signed({2'b00, r4});
    end else begin
      m_t = $signed({2'b00, r4}) - $signed({2'b00, peff, 2'b00});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
      g_vld <= 1'b0;
      h_vld <= 1'b0;
      i_vld <= 1'b0;
    end else if (en) begin
      f_vld <= m_vld[NM-1];
      g_vld <= f_vld;
      h_vld <= g_vld;
      i_vld <= h_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_win  <= m_win[NM-1];
      f_r    <= (m_neg[NM-1] && m_rem[NM-1] != '0) ? peff - m_rem[NM-1] : m_rem[NM-1];
      g_win  <= f_win;
      g_m    <= 33'(m_t);
      h_win  <= g_win;
      h_prod <= amplitude * g_m;
      i_win  <= h_win;
      i_neg  <= h_prod[64];
      i_mag  <= h_prod[64] ? 63'(-h_prod) : 63'(h_prod);
    end
  end

  // Scaling by the period. The quotient fits in 32 bits, so the top bits
  // of the magnitude seed the remainder and 32 stages remain.
  logic        dv_vld [ND];
  logic        dv_win [ND];
  logic        dv_neg [ND];
  logic [30:0] dv_rem [ND];
  logic [31:0] dv_mag [ND];
  logic [31:0] dv_q   [ND];
  logic [31:0] dv_res [ND];

  always_comb begin
    for (int k = 0; k < ND; k++) begin
      if (k == 0) begin
        dv_res[k] = wtw_pkg::rem_step(i_mag[62:32], i_mag[31], peff);
      end else begin
        dv_res[k] = wtw_pkg::rem_step(dv_rem[k-1], dv_mag[k-1][31], peff);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ND; k++) dv_vld[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < ND; k++) dv_vld[k] <= (k == 0) ? i_vld : dv_vld[k-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ND; k++) begin
        dv_rem[k] <= dv_res[k][30:0];
        if (k == 0) begin
          dv_win[k] <= i_win;
          dv_neg[k] <= i_neg;
          dv_mag[k] <= {i_mag[30:0], 1'b0};
          dv_q[k]   <= {31'b0, dv_res[k][31]};
        end else begin
          dv_win[k] <= dv_win[k-1];
          dv_neg[k] <= dv_neg[k-1];
          dv_mag[k] <= {dv_mag[k-1][30:0], 1'b0};
          dv_q[k]   <= {dv_q[k-1][30:0], dv_res[k][31]};
        end
      end
    end
  end

  // Signed quotient rounded toward minus infinity.
  logic        j_vld, j_win;
  logic signed [33:0] j_q;
  logic signed [33:0] q_pos;
  assign q_pos = $signed({2'b00, dv_q[ND-1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      j_vld <= 1'b0;
    end else if (en) begin
      j_vld <= dv_vld[ND-1];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      j_win <= dv_win[ND-1];
      if (dv_neg[ND-1]) begin
        j_q <= (dv_rem[ND-1] != '0) ? -(q_pos + 34'sd1) : -q_pos;
      end else begin
        j_q <= q_pos;
      end
    end
  end

  // Output register: add the zero offset, saturate, and apply the window
  // and the zero-amplitude case.
  logic signed [34:0] w;
  logic [31:0]        w_sat;
  assign w = 35'(j_q) + 35'(zero_offset);

  always_comb begin
    if (w[34:31] == 4'b0000 || w[34:31] == 4'b1111) begin
      w_sat = w[31:0];
    end else begin
      w_sat = w[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= j_vld;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tuser <= j_win;
      if (!j_win) begin
        m_axis_tdata <= '0;
      end else if (amplitude == '0) begin
        m_axis_tdata <= zero_offset;
      end else begin
        m_axis_tdata <= w_sat;
      end
    end
  end

endmodule
`default_nettype wire
